// ===== design/uart_command_frame_parser_defines.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef UART_COMMAND_FRAME_PARSER_DEFINES_SVH
`define UART_COMMAND_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, quiet during reset.
`define UCFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucfp check failed");
// Next-cycle implication, sampled on clk_i, quiet during reset.
`define UCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucfp check failed");
`else
`define UCFP_ASSERT_NOW(label, ante, cons)
`define UCFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/ucfp_pkg.sv =====
`default_nettype none
package ucfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FAULT_W = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'hFC;
  localparam logic [BYTE_W-1:0] TAIL_FIRST  = 8'hA1;
  localparam logic [BYTE_W-1:0] TAIL_SECOND = 8'hA2;

  localparam logic [BYTE_W-1:0] LENGTH_LIMIT_RESET  = 8'd100;
  localparam logic [BYTE_W-1:0] COMMAND_LIMIT_RESET = 8'hF1;

  // Register index, taken from paddr[2].
  localparam logic REG_LENGTH_LIMIT  = 1'b0;
  localparam logic REG_COMMAND_LIMIT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_SUM_GOOD = 2'd1,
    KIND_SUM_BAD  = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HEAD2 = 8'b0000_0010,
    PH_CMD   = 8'b0000_0100,
    PH_LEN   = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CHECK = 8'b0010_0000,
    PH_TAIL1 = 8'b0100_0000,
    PH_TAIL2 = 8'b1000_0000
  } phase_e;

endpackage
`default_nettype wire

// ===== design/ucfp_rx_if.sv =====
`default_nettype none
interface ucfp_rx_if;
  import ucfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== design/ucfp_res_if.sv =====
`default_nettype none
interface ucfp_res_if;
  import ucfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  byte_value;
  logic [BYTE_W-1:0]  payload_length;
  logic [FAULT_W-1:0] fault_count;

  modport source (output valid, output kind, output byte_value, output payload_length,
                  output fault_count, input ready);
  modport sink   (input valid, input kind, input byte_value, input payload_length,
                  input fault_count, output ready);
endinterface
`default_nettype wire

// ===== design/uart_command_frame_parser.sv =====
// Serial command frame parser. Each item on rx_i is one received byte; the
// parser follows the layout FF FC <command> <length> <payload...> <xor> A1 A2
// and emits at most one item on res_o per byte: every payload byte as it
// arrives (kind 0, with the frame length), and at the second tail byte the
// command and length with kind 1 (XOR of header, command, length and payload
// matches the check byte) or kind 2 (mismatch). An unexpected byte, including
// garbage while idle, a zero length or a command/length at or above its limit
// register, drops the frame, returns to idle and bumps the wrapping 32-bit
// fault count that rides along with every result. Rate: one byte per clock
// cycle while res_o keeps up; a result appears in the cycle after its byte is
// taken. rx_i.ready falls only while the single result register holds an item
// res_o has not yet taken. Limits are written over the APB port (length_limit
// at 0x0, command_limit at 0x4) by the user while idle; the block does not check.
`default_nettype none
`include "uart_command_frame_parser_defines.svh"
module uart_command_frame_parser
  import ucfp_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [ADDR_W-1:0]  paddr,
  input  wire  [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  ucfp_rx_if.sink            rx_i,
  ucfp_res_if.source         res_o
);

  // Configuration registers
  logic [BYTE_W-1:0] len_limit_q, cmd_limit_q;
  logic              cfg_wr;

  // Parser state
  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  remain_q, remain_d;
  logic [BYTE_W-1:0]  cmd_q, cmd_d;
  logic [BYTE_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0]  xor_q, xor_d;
  logic [BYTE_W-1:0]  chk_q, chk_d;
  logic [FAULT_W-1:0] fault_q, fault_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, emit_kind;
  logic [BYTE_W-1:0]  out_byte_q, emit_byte;
  logic [BYTE_W-1:0]  out_len_q;
  logic [FAULT_W-1:0] out_fault_q;

  logic              accept, emit, reject;
  logic [BYTE_W-1:0] b;

  // APB: always ready, register picked by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[2])
      REG_LENGTH_LIMIT:  prdata = {{(DATA_W-BYTE_W){1'b0}}, len_limit_q};
      REG_COMMAND_LIMIT: prdata = {{(DATA_W-BYTE_W){1'b0}}, cmd_limit_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit_q <= LENGTH_LIMIT_RESET;
      cmd_limit_q <= COMMAND_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LENGTH_LIMIT) len_limit_q <= pwdata[BYTE_W-1:0];
      if (paddr[2] == REG_COMMAND_LIMIT) cmd_limit_q <= pwdata[BYTE_W-1:0];
    end
  end

  // Take a new byte whenever the result register is empty or being drained
  assign rx_i.ready = ~out_valid_q | res_o.ready;
  assign accept     = rx_i.valid & rx_i.ready;
  assign b          = rx_i.rx_byte;

  // Per-byte state update
  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    xor_d     = xor_q;
    chk_d     = chk_q;
    emit      = 1'b0;
    reject    = 1'b0;
    emit_kind = KIND_PAYLOAD;
    emit_byte = b;

    case (phase_q)
      PH_IDLE: begin
        if (b == HEAD_FIRST) begin
          xor_d   = b;
          phase_d = PH_HEAD2;
        end else begin
          reject = 1'b1;
        end
      end
      PH_HEAD2: begin
        if (b == HEAD_SECOND) begin
          xor_d   = xor_q ^ b;
          phase_d = PH_CMD;
        end else begin
          reject = 1'b1;
        end
      end
      PH_CMD: begin
        if (b < cmd_limit_q) begin
          cmd_d   = b;
          xor_d   = xor_q ^ b;
          phase_d = PH_LEN;
        end else begin
          reject = 1'b1;
        end
      end
      PH_LEN: begin
        if ((b != '0) && (b < len_limit_q)) begin
          len_d    = b;
          remain_d = b;
          xor_d    = xor_q ^ b;
          phase_d  = PH_DATA;
        end else begin
          reject = 1'b1;
        end
      end
      PH_DATA: begin
        xor_d    = xor_q ^ b;
        remain_d = remain_q - 1'b1;
        if (remain_d == '0) phase_d = PH_CHECK;
        emit = 1'b1;
      end
      PH_CHECK: begin
        // Any check value passes here; a mismatch shows only as a bad frame end
        chk_d   = b;
        phase_d = PH_TAIL1;
      end
      PH_TAIL1: begin
        if (b == TAIL_FIRST) phase_d = PH_TAIL2;
        else reject = 1'b1;
      end
      PH_TAIL2: begin
        if (b == TAIL_SECOND) begin
          phase_d   = PH_IDLE;
          emit      = 1'b1;
          emit_kind = (xor_q == chk_q) ? KIND_SUM_GOOD : KIND_SUM_BAD;
          emit_byte = cmd_q;
        end else begin
          reject = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // Drop the frame and count the byte
    if (reject) phase_d = PH_IDLE;
    fault_d = reject ? fault_q + 1'b1 : fault_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      remain_q <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      xor_q    <= '0;
      chk_q    <= '0;
      fault_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      xor_q    <= xor_d;
      chk_q    <= chk_d;
      fault_q  <= fault_d;
    end
  end

  // Result register: load on an emitting byte, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  // Results never coincide with a reject, so the current count is the one to report
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_kind_q  <= emit_kind;
      out_byte_q  <= emit_byte;
      out_len_q   <= len_q;
      out_fault_q <= fault_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = out_kind_q;
  assign res_o.byte_value     = out_byte_q;
  assign res_o.payload_length = out_len_q;
  assign res_o.fault_count    = out_fault_q;

  // A payload phase always has at least one byte left to go
  `UCFP_ASSERT_NOW(a_remain_nonzero, phase_q == PH_DATA, remain_q != '0)
  // A rejected byte always lands the parser in idle
  `UCFP_ASSERT_NEXT(a_reject_idle, accept && reject, phase_q == PH_IDLE)
  // The fault count moves by at most one per cycle
  `UCFP_ASSERT_NEXT(a_fault_step, 1'b1,
                    fault_q == $past(fault_q) || fault_q == $past(fault_q) + 1'b1)
  // A payload byte taken always yields a payload result next cycle
  `UCFP_ASSERT_NEXT(a_data_emits, accept && phase_q == PH_DATA,
                    out_valid_q && out_kind_q == KIND_PAYLOAD)
  // Input stalls only behind a held result
  `UCFP_ASSERT_NOW(a_stall_cause, !rx_i.ready, out_valid_q && !res_o.ready)

endmodule
`default_nettype wire
